/* src/stl_pkg.sv */
// stl_pkg: shared widths, codes, item structs and slot helpers for the laplacian stencil
// no dependencies; imported by every module of the block but stl_ram
package stl_pkg;

  // line store geometry
  localparam int MAX_COLS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int NSLOTS   = 3;

  // field widths
  localparam int ROW_W    = 16;
  localparam int LC_W     = 10;
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 24;
  localparam int VALUE_W  = 52;
  localparam int DIFF_W   = SAMPLE_W + 2;
  localparam int PROD_W   = DIFF_W + COEF_W + 1;

  // effective last column limit, as a column field value
  localparam int COL_LIM_INT = (MAX_COLS - 1 < (1 << LC_W) - 1) ? MAX_COLS - 1 : (1 << LC_W) - 1;
  localparam logic [LC_W-1:0] COL_LIM = LC_W'(COL_LIM_INT);

  // stream widths
  localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_USED_W = VALUE_W + ROW_W + LC_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAST_ROW = 2'd0,
    CFG_LAST_COL = 2'd1,
    CFG_COEF_X   = 2'd2,
    CFG_COEF_Y   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_DRAIN  = 1'b1
  } kind_t;

  typedef logic [$clog2(NSLOTS)-1:0] slot_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [LC_W-1:0]  col;
    logic             last;
  } res_meta_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] centre;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] up;
    logic signed [SAMPLE_W-1:0] down;
    res_meta_t                  meta;
  } tap_t;

  function automatic slot_t slot_dec(input slot_t s);
    return (s == slot_t'(0)) ? slot_t'(NSLOTS - 1) : s - 1'b1;
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    return (s == slot_t'(NSLOTS - 1)) ? slot_t'(0) : s + 1'b1;
  endfunction

  // row mod 3: base-4 digits sum to the same residue since 4 is 1 mod 3
  function automatic slot_t row_slot(input logic [ROW_W-1:0] r);
    logic [4:0] acc;
    logic [3:0] s1;
    logic [2:0] s2;
    acc = '0;
    for (int i = 0; i < ROW_W / 2; i++) begin
      acc = acc + 5'(r[2*i +: 2]);
    end
    s1 = 4'(acc[4:2]) + 4'(acc[1:0]);
    s2 = 3'(s1[3:2]) + 3'(s1[1:0]);
    return (s2 >= 3'(NSLOTS)) ? slot_t'(s2 - 3'(NSLOTS)) : slot_t'(s2);
  endfunction

endpackage

/* src/stl_ram.sv */
// stl_ram: generic one-write, two-read memory with registered read data
// no dependencies
module stl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/stl_front.sv */
// stl_front: input acceptance, raster counters, three-row line store and tap gathering
// depends on stl_pkg and stl_ram
module stl_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [stl_pkg::SAMPLE_W-1:0]        sample,
  input  logic                                kind,
  input  logic [stl_pkg::ROW_W-1:0]           last_row,
  input  logic [stl_pkg::LC_W-1:0]            last_col,
  input  stl_pkg::slot_t                      last_slot,
  input  logic [stl_pkg::QCNT_W-1:0]          q_count,
  output logic                                push,
  output stl_pkg::tap_t                       push_data
);
  import stl_pkg::*;

  typedef struct packed {
    slot_t                      ctr_slot;
    slot_t                      up_slot;
    logic                       has_left;
    logic                       has_right;
    logic                       has_up;
    logic signed [SAMPLE_W-1:0] down;
    res_meta_t                  meta;
  } rd_tag_t;

  logic [ROW_W-1:0] in_row, in_row_next;
  logic [LC_W-1:0]  in_col, in_col_next;
  slot_t            in_slot, in_slot_next;
  logic [LC_W-1:0]  drain_col, drain_col_next;

  logic             rd_valid;
  rd_tag_t          rd_tag;
  rd_tag_t          tag_next;
  logic             has_result;

  logic [LC_W-1:0]  lc;
  logic             is_drain;
  logic             accept;
  logic             over;
  logic [ROW_W-1:0] r;
  slot_t            s;
  logic [LC_W-1:0]  c_smp, c_drn, c;
  logic [QCNT_W:0]  used;

  logic [COL_W-1:0] addr_l, addr_c, addr_r;
  logic [SAMPLE_W-1:0] rd_left [NSLOTS];
  logic [SAMPLE_W-1:0] rd_ctr [NSLOTS];
  logic [SAMPLE_W-1:0] rd_right [NSLOTS];
  logic [SAMPLE_W-1:0] rd_up [NSLOTS];

  // credits: queue entries plus the item in the read cycle
  assign used     = {1'b0, q_count} + {{QCNT_W{1'b0}}, rd_valid};
  assign s_tready = (used < (QCNT_W + 1)'(QDEPTH));
  assign accept   = s_tvalid && s_tready;

  assign lc       = (int'(last_col) < COL_LIM_INT) ? last_col : COL_LIM;
  assign is_drain = (kind == KIND_DRAIN);

  always_comb begin
    over  = (in_row > last_row);
    r     = over ? last_row : in_row;
    s     = over ? last_slot : in_slot;
    c_smp = (in_col > lc) ? lc : in_col;
    c_drn = (drain_col > lc) ? lc : drain_col;
    c     = is_drain ? c_drn : c_smp;

    tag_next.has_left  = (c != '0);
    tag_next.has_right = (c < lc);
    tag_next.meta.col  = c;
    if (is_drain) begin
      tag_next.ctr_slot  = last_slot;
      tag_next.up_slot   = slot_dec(last_slot);
      tag_next.has_up    = (last_row != '0);
      tag_next.down      = '0;
      tag_next.meta.row  = last_row;
      tag_next.meta.last = (c_drn >= lc);
      has_result         = 1'b1;
    end else begin
      tag_next.ctr_slot  = slot_dec(s);
      tag_next.up_slot   = slot_dec(slot_dec(s));
      tag_next.has_up    = (r > ROW_W'(1));
      tag_next.down      = $signed(sample);
      tag_next.meta.row  = r - 1'b1;
      tag_next.meta.last = 1'b0;
      has_result         = (r != '0);
    end
  end

  always_comb begin
    in_row_next    = in_row;
    in_col_next    = in_col;
    in_slot_next   = in_slot;
    drain_col_next = drain_col;
    if (is_drain) begin
      drain_col_next = (c_drn >= lc) ? '0 : c_drn + 1'b1;
    end else if (c_smp >= lc) begin
      in_col_next  = '0;
      in_row_next  = (r >= last_row) ? '0 : r + 1'b1;
      in_slot_next = (r >= last_row) ? slot_t'(0) : slot_inc(s);
    end else begin
      in_col_next  = c_smp + 1'b1;
      in_row_next  = r;
      in_slot_next = s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row    <= '0;
      in_col    <= '0;
      in_slot   <= '0;
      drain_col <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (accept) begin
        in_row    <= in_row_next;
        in_col    <= in_col_next;
        in_slot   <= in_slot_next;
        drain_col <= drain_col_next;
      end
      rd_valid <= accept && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_tag <= tag_next;
    end
  end

  // column c-1, c and c+1; out-of-grid reads are masked later
  assign addr_l = COL_W'(c - 1'b1);
  assign addr_c = COL_W'(c);
  assign addr_r = COL_W'(c + 1'b1);

  // two copies per row slot give three reads in the same row plus one in another
  for (genvar g = 0; g < NSLOTS; g++) begin : g_slot
    logic we;
    assign we = accept && !is_drain && (s == slot_t'(g));

    stl_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_ram_lc (
      .clk     (clk),
      .we      (we),
      .waddr   (addr_c),
      .wdata   (sample),
      .raddr_a (addr_l),
      .rdata_a (rd_left[g]),
      .raddr_b (addr_c),
      .rdata_b (rd_ctr[g])
    );

    stl_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_ram_rc (
      .clk     (clk),
      .we      (we),
      .waddr   (addr_c),
      .wdata   (sample),
      .raddr_a (addr_r),
      .rdata_a (rd_right[g]),
      .raddr_b (addr_c),
      .rdata_b (rd_up[g])
    );
  end

  assign push = rd_valid;

  always_comb begin
    push_data.centre = $signed(rd_ctr[rd_tag.ctr_slot]);
    push_data.left   = rd_tag.has_left ? $signed(rd_left[rd_tag.ctr_slot]) : '0;
    push_data.right  = rd_tag.has_right ? $signed(rd_right[rd_tag.ctr_slot]) : '0;
    push_data.up     = rd_tag.has_up ? $signed(rd_up[rd_tag.up_slot]) : '0;
    push_data.down   = rd_tag.down;
    push_data.meta   = rd_tag.meta;
  end

endmodule

/* src/stl_fifo.sv */
// stl_fifo: short register queue of gathered taps between front and back
// depends on stl_pkg
module stl_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  stl_pkg::tap_t              push_data,
  input  logic                       pop,
  output stl_pkg::tap_t              pop_data,
  output logic                       empty,
  output logic [stl_pkg::QCNT_W-1:0] count
);
  import stl_pkg::*;

  tap_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/stl_back.sv */
// stl_back: second differences, coefficient multiplies, final sum and output register
// depends on stl_pkg
module stl_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [stl_pkg::COEF_W-1:0]   coef_x,
  input  logic [stl_pkg::COEF_W-1:0]   coef_y,
  input  logic                         q_empty,
  input  stl_pkg::tap_t                q_data,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [stl_pkg::VALUE_W-1:0]  value,
  output stl_pkg::res_meta_t           meta
);
  import stl_pkg::*;

  logic adv;

  logic                     a_valid;
  logic signed [DIFF_W-1:0] a_dx, a_dy;
  res_meta_t                a_meta;

  logic                     b_valid;
  logic signed [PROD_W-1:0] b_px, b_py;
  res_meta_t                b_meta;

  logic signed [DIFF_W-1:0] dx, dy;

  // whole pipe moves unless the result register holds an untaken result
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !q_empty;

  always_comb begin
    dx = DIFF_W'(q_data.up) + DIFF_W'(q_data.down) - (DIFF_W'(q_data.centre) <<< 1);
    dy = DIFF_W'(q_data.left) + DIFF_W'(q_data.right) - (DIFF_W'(q_data.centre) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      a_valid  <= pop;
      b_valid  <= a_valid;
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx   <= dx;
      a_dy   <= dy;
      a_meta <= q_data.meta;
      b_px   <= PROD_W'(a_dx) * PROD_W'($signed({1'b0, coef_x}));
      b_py   <= PROD_W'(a_dy) * PROD_W'($signed({1'b0, coef_y}));
      b_meta <= a_meta;
      value  <= VALUE_W'(VALUE_W'(b_px) + VALUE_W'(b_py));
      meta   <= b_meta;
    end
  end

endmodule

/* src/grid_laplacian_stencil.sv */
// grid_laplacian_stencil: five-point laplacian over a raster grid stream
// depends on stl_pkg, stl_front, stl_fifo, stl_back (and stl_ram through stl_front)
// path: a result reaches the master side from the transfer of the item that causes it
//   through the line store read, the queue, the differences, the multiplies and the sum
//   into the output register; throughput is one item per cycle while the queue has credits,
//   set by the line store banks giving all taps in one read
// reset: rst (synchronous) clears the raster and drain counters, the queue and all valid
//   bits and loads the registers with their defaults; the line store is not cleared
module grid_laplacian_stencil (
  input  logic                              clk,
  input  logic                              rst,
  // slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [stl_pkg::IN_DATA_W-1:0]     s_tdata,   // [23:0] sample
  input  logic                              s_tuser,   // [0] kind: 0 sample, 1 drain
  // master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [stl_pkg::OUT_DATA_W-1:0]    m_tdata,   // [51:0] value, [67:52] row,
                                                       // [77:68] col, [79:78] zero
  output logic                              m_tlast,   // final grid point
  // configuration write port
  input  logic                              cfg_we,
  input  logic [stl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stl_pkg::CFG_W-1:0]         cfg_data
);
  import stl_pkg::*;

  // configuration registers
  logic [ROW_W-1:0]  last_row;
  logic [LC_W-1:0]   last_col;
  logic [COEF_W-1:0] coef_x;
  logic [COEF_W-1:0] coef_y;
  slot_t             last_slot;   // last_row mod 3, kept alongside last_row

  // front to queue
  logic              push;
  tap_t              push_data;
  logic [QCNT_W-1:0] q_count;

  // queue to back
  logic              pop;
  logic              q_empty;
  tap_t              q_data;

  logic [VALUE_W-1:0] value;
  res_meta_t          meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_row  <= ROW_W'(1);
      last_col  <= LC_W'(1);
      coef_x    <= COEF_W'(65536);
      coef_y    <= COEF_W'(65536);
      last_slot <= slot_t'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LAST_ROW: begin
          last_row  <= cfg_data[ROW_W-1:0];
          last_slot <= row_slot(cfg_data[ROW_W-1:0]);
        end
        CFG_LAST_COL: last_col <= cfg_data[LC_W-1:0];
        CFG_COEF_X:   coef_x   <= cfg_data[COEF_W-1:0];
        CFG_COEF_Y:   coef_y   <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // front: counters, line store, tap gathering; stops on queue credits
  stl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .sample    (s_tdata[SAMPLE_W-1:0]),
    .kind      (s_tuser),
    .last_row  (last_row),
    .last_col  (last_col),
    .last_slot (last_slot),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  // queue lets the back side stall without losing reads already issued
  stl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  // back: arithmetic pipe ending in the output register
  stl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .coef_x   (coef_x),
    .coef_y   (coef_y),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .value    (value),
    .meta     (meta)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, meta.col, meta.row, value};
  assign m_tlast = meta.last;

endmodule

/* src/stl_checker.sv */
// stl_checker: port-level assertions for grid_laplacian_stencil, bound to the top level
// depends on stl_pkg and grid_laplacian_stencil
module stl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [stl_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import stl_pkg::*;

  // out of reset the block takes items and shows no valid result
  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
    else $error("state after reset wrong");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // padding above the col field stays zero
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1 -: OUT_PAD_W] == '0)
    else $error("output padding not zero");

endmodule

bind grid_laplacian_stencil stl_checker u_checker (.*);

/* sim/testbench.sv */
// testbench for grid_laplacian_stencil: raster grids, drain ticks and register changes
// checked against a cycle-free five-point laplacian predictor held in a scoreboard class
// depends on stl_pkg and the grid_laplacian_stencil rtl
`timescale 1ns / 1ps

module testbench;
  import stl_pkg::*;

  localparam int ITEMS_TARGET  = 1450;
  localparam int SETTLE_CYCLES = 12;      // pipeline is 5 deep, row zero samples leave no result
  localparam int CYCLE_LIMIT   = 600000;

  // one expected or observed point of the laplacian
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [ROW_W-1:0]          row;
    logic [LC_W-1:0]           col;
    logic                      last;
  } grid_point_t;

  // predictor state plus the queue of points still owed by the block
  class stencil_scoreboard;
    logic signed [SAMPLE_W-1:0] line_rows [NSLOTS][MAX_COLS];
    bit                         filled    [NSLOTS][MAX_COLS];
    int                         next_row, next_col, drain_pos;
    int                         last_row, last_col;
    longint                     coef_x, coef_y;
    grid_point_t                pending_points [$];
    int                         mismatches, points_checked;

    function new();
      next_row       = 0;
      next_col       = 0;
      drain_pos      = 0;
      last_row       = 1;
      last_col       = 1;
      coef_x         = 65536;
      coef_y         = 65536;
      mismatches     = 0;
      points_checked = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, int unsigned val);
      case (idx)
        CFG_LAST_ROW: last_row = int'(val & 32'hFFFF);
        CFG_LAST_COL: last_col = int'(val & 32'h3FF);
        CFG_COEF_X:   coef_x   = longint'(val & 32'hFFFFFF);
        CFG_COEF_Y:   coef_y   = longint'(val & 32'hFFFFFF);
        default: ;
      endcase
    endfunction

    function int col_end();
      return (last_col < MAX_COLS - 1) ? last_col : MAX_COLS - 1;
    endfunction

    // grid row r lives in slot r mod 3
    function longint tap(int r, int c);
      return longint'(line_rows[r % NSLOTS][c]);
    endfunction

    function bit is_filled(int r, int c);
      return filled[r % NSLOTS][c];
    endfunction

    function bit at_boundary();
      return (next_row == 0) && (next_col == 0);
    endfunction

    function longint laplacian_at(longint up, longint down, longint lft, longint rgt,
                                  longint ctr);
      return (up + down - 2 * ctr) * coef_x + (lft + rgt - 2 * ctr) * coef_y;
    endfunction

    // stencil around (r, c); neighbours off the grid read as zero
    function grid_point_t point_at(int r, int c, longint down);
      int          lc;
      longint      lft, rgt, up;
      grid_point_t p;
      lc  = col_end();
      lft = (c > 0) ? tap(r, c - 1) : 0;
      rgt = (c < lc) ? tap(r, c + 1) : 0;
      up  = (r > 0) ? tap(r - 1, c) : 0;
      p.value = VALUE_W'(laplacian_at(up, down, lft, rgt, tap(r, c)));
      p.row   = ROW_W'(r);
      p.col   = LC_W'(c);
      p.last  = 1'b0;
      return p;
    endfunction

    // a drain tick only reads entries that some sample has written
    function bit drain_covered();
      int lc, r, c;
      lc = col_end();
      r  = last_row;
      c  = (drain_pos < lc) ? drain_pos : lc;
      return is_filled(r, c) && (c == 0 || is_filled(r, c - 1)) &&
             (c >= lc || is_filled(r, c + 1)) && (r == 0 || is_filled(r - 1, c));
    endfunction

    function void note_input(kind_t kind, logic [SAMPLE_W-1:0] smp);
      int          lc, r, c;
      grid_point_t p;
      lc = col_end();
      if (kind == KIND_DRAIN) begin
        // final row, nothing below; last on the final column
        r = last_row;
        c = (drain_pos < lc) ? drain_pos : lc;
        p = point_at(r, c, 0);
        p.last = (c >= lc);
        drain_pos = (c >= lc) ? 0 : c + 1;
        pending_points.push_back(p);
      end else begin
        // counters beyond the limits are clamped to the last row or column
        r = (next_row < last_row) ? next_row : last_row;
        c = (next_col < lc) ? next_col : lc;
        if (r >= 1) begin
          pending_points.push_back(point_at(r - 1, c, longint'($signed(smp))));
        end
        line_rows[r % NSLOTS][c] = smp;
        filled[r % NSLOTS][c]    = 1'b1;
        if (c >= lc) begin
          next_col = 0;
          next_row = (r >= last_row) ? 0 : r + 1;
        end else begin
          next_col = c + 1;
          next_row = r;
        end
      end
    endfunction

    function void check_point(logic [OUT_DATA_W-1:0] data, logic tlast);
      grid_point_t               want;
      logic signed [VALUE_W-1:0] got_value;
      logic [ROW_W-1:0]          got_row;
      logic [LC_W-1:0]           got_col;
      got_value = data[VALUE_W-1:0];
      got_row   = data[VALUE_W +: ROW_W];
      got_col   = data[VALUE_W + ROW_W +: LC_W];
      if (pending_points.size() == 0) begin
        $error("result transfer with nothing expected: value %0d row %0d col %0d",
               got_value, got_row, got_col);
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      points_checked++;
      if (got_value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, got_value);
        mismatches++;
      end
      if (got_row !== want.row) begin
        $error("row: expected %0d, actual %0d", want.row, got_row);
        mismatches++;
      end
      if (got_col !== want.col) begin
        $error("col: expected %0d, actual %0d", want.col, got_col);
        mismatches++;
      end
      if (tlast !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, tlast);
        mismatches++;
      end
    endfunction
  endclass

  // all block inputs start at known values
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = KIND_SAMPLE;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  stencil_scoreboard sb = new();

  bit tx_calm = 1'b0;   // sender runs back to back
  bit rx_calm = 1'b0;   // receiver never stalls
  int rx_hold = 0;
  int items_sent     = 0;
  int drains_sent    = 0;
  int settings_used  = 0;
  int cycle_count    = 0;

  grid_laplacian_stencil DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [23:0] sample
    .s_tuser  (s_tuser),    // [0] kind
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [51:0] value, [67:52] row, [77:68] col
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check each transfer, then hold ready low for a random stall
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        sb.check_point(m_tdata, m_tlast);
        rx_hold = rx_calm ? 0 : $urandom_range(0, 19);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0, 1:    return 24'h7FFFFF;
      2, 3:    return 24'h800000;
      4:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic longint pick_coef();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 24'hFFFFFF;
      2:       return 65536;
      default: return $urandom_range(0, 24'hFFFFFF);
    endcase
  endfunction

  // one slave-side transfer; valid stays high when the next item follows at once
  task automatic send_item(input kind_t kind, input logic [SAMPLE_W-1:0] smp);
    kind_t k;
    int    gap;
    k = kind;
    // a drain over a row that was never filled turns into a sample
    if (k == KIND_DRAIN && !sb.drain_covered()) k = KIND_SAMPLE;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    sb.note_input(k, smp);
    items_sent++;
    if (k == KIND_DRAIN) drains_sent++;
  endtask

  // stop sending and let every owed result come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input longint val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    sb.set_reg(idx, 32'(CFG_W'(val)));
    @(posedge clk);
  endtask

  task automatic load_registers(input int lr, input int lc, input longint cx, input longint cy);
    write_reg(CFG_LAST_ROW, lr);
    write_reg(CFG_LAST_COL, lc);
    write_reg(CFG_COEF_X, cx);
    write_reg(CFG_COEF_Y, cy);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // finish the grid in flight, with the odd drain tick thrown in
  task automatic send_grid_rest(input int noise_pct);
    while (!sb.at_boundary()) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(KIND_DRAIN, SAMPLE_W'($urandom));
      else send_item(KIND_SAMPLE, rand_sample());
    end
  endtask

  // drain ticks until the final row wraps back to column zero
  task automatic drain_all();
    if (sb.drain_covered()) begin
      do send_item(KIND_DRAIN, SAMPLE_W'($urandom)); while (sb.drain_pos != 0);
    end
  endtask

  // one register setting, at times shrunk mid grid, and a few grids under it
  task automatic run_segment();
    int lr, lc, grids, cut, tail;
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    send_grid_rest(0);
    wait_idle();
    lr = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 10);
    lc = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 30);
    load_registers(lr, lc, pick_coef(), pick_coef());
    grids = $urandom_range(1, 3);
    repeat (grids) begin
      send_item(KIND_SAMPLE, rand_sample());
      // now and then shrink the grid while it is half sent
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(0, 2 * sb.last_col);
        repeat (cut) begin
          if (!sb.at_boundary()) send_item(KIND_SAMPLE, rand_sample());
        end
        if (!sb.at_boundary()) begin
          wait_idle();
          load_registers($urandom_range(1, sb.last_row), $urandom_range(1, sb.last_col),
                         sb.coef_x, sb.coef_y);
        end
      end
      send_grid_rest(8);
      tail = $urandom_range(0, 19);
      if (tail < 14) begin
        drain_all();
      end else if (tail < 17) begin
        repeat ($urandom_range(1, sb.col_end())) send_item(KIND_DRAIN, SAMPLE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: 2x2 grid of full-scale samples, then its final row
    send_item(KIND_SAMPLE, 24'h7FFFFF);
    send_item(KIND_SAMPLE, 24'h800000);
    send_item(KIND_SAMPLE, 24'h800000);
    send_item(KIND_SAMPLE, 24'h7FFFFF);
    drain_all();

    // largest weights on columns of alternating extremes
    wait_idle();
    load_registers(2, 1, 24'hFFFFFF, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) send_item(KIND_SAMPLE, i[0] ? 24'h800000 : 24'h7FFFFF);
    drain_all();

    // widest limits, then shrink mid row so the column counter sits past the end
    wait_idle();
    load_registers(65535, 1023, 0, 1);
    repeat (5) send_item(KIND_SAMPLE, rand_sample());
    wait_idle();
    load_registers(1, 1, 0, 1);
    send_grid_rest(0);
    drain_all();

    while (items_sent < ITEMS_TARGET) run_segment();

    wait_idle();
    $display("covered %0d input transfers (%0d drain ticks) over %0d register settings",
             items_sent, drains_sent, settings_used);
    $display("compared %0d result transfers field by field, %0d mismatches",
             sb.points_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
